[rtl/quoted_utf8_string_encoder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quoted UTF-8 string encoder
// Same-cycle and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_UTF8_STRING_ENCODER_ASSERT_SVH
`define QUOTED_UTF8_STRING_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QU8_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define QU8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/qu8enc_pkg.sv]
// ----------------------------------------------------------------------------
// qu8enc_pkg
// Types and constants shared by the quoted UTF-8 encoder modules.
// ----------------------------------------------------------------------------
package qu8enc_pkg;

    localparam int MAX_BYTES     = 6;
    localparam int LEN_W         = 3;
    localparam int CP_W          = 31;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0]  QUOTE_BYTE = 8'h22;
    localparam logic [7:0]  CONT_TAG   = 8'h80;
    localparam logic [31:0] MASK_2B    = 32'hfffff800;
    localparam logic [31:0] MASK_3B    = 32'hffff0000;
    localparam logic [31:0] MASK_4B    = 32'hffe00000;
    localparam logic [31:0] MASK_5B    = 32'hfc000000;
    localparam logic [7:0]  LEAD_2B    = 8'hc0;
    localparam logic [7:0]  LEAD_3B    = 8'he0;
    localparam logic [7:0]  LEAD_4B    = 8'hf0;
    localparam logic [7:0]  LEAD_5B    = 8'hf8;
    localparam logic [7:0]  LEAD_6B    = 8'hfc;

    typedef enum logic [1:0] {
        MODE_CHAR  = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_CLOSE = 2'd2
    } t_mode;

    // One classified item: byte count and bytes in stream order (index 0 first).
    typedef struct packed {
        logic [LEN_W-1:0]           len;
        logic [MAX_BYTES-1:0][7:0]  bytes;
    } t_entry;

endpackage

[rtl/quoted_utf8_string_encoder.sv]
// ----------------------------------------------------------------------------
// quoted_utf8_string_encoder
// Code points and quote marks in, quoted UTF-8 bytes out (31-bit legacy form).
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------
//  in      | input     | i_valid / o_stall | i_mode, i_code_point
//  out     | output    | o_valid / i_stall | o_out_byte, o_last_of_item
//
//  One byte leaves per cycle while i_stall is low; an item of N bytes (1 to 6)
//  holds the back end until its last byte leaves, so with no output stall the
//  input sustains one item per cycle for one-byte items. First byte becomes
//  valid after the queue write and then the output register load.
//  Items with the unused mode are accepted and produce no bytes.
//  Reset clears queue pointers, byte index and output valid; no clearing pass.
//  o_stall rises only when the item queue is full; i_stall holds the output.
// ----------------------------------------------------------------------------
module quoted_utf8_string_encoder import qu8enc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_mode,
    input  logic [CP_W-1:0] i_code_point,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_item
);

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    qu8enc_front u_front (
        .i_valid      (i_valid),
        .i_mode       (i_mode),
        .i_code_point (i_code_point),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    qu8enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_entry)
    );

    qu8enc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head_entry),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

endmodule

[rtl/qu8enc_front.sv]
// ----------------------------------------------------------------------------
// qu8enc_front
// Accepts input transactions and classifies each into a byte sequence.
// ----------------------------------------------------------------------------
module qu8enc_front import qu8enc_pkg::*; (
    input  logic            i_valid,
    input  logic [1:0]      i_mode,
    input  logic [CP_W-1:0] i_code_point,
    input  logic            i_full,
    output logic            o_stall,
    output logic            o_push,
    output t_entry          o_entry
);

    logic [31:0]     cp32;
    logic [4:0][7:0] cont;

    assign cp32    = {1'b0, i_code_point};
    assign o_stall = i_full;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            cont[k] = CONT_TAG | {2'b00, i_code_point[6*k +: 6]};
        end
    end

    always_comb begin
        o_entry = '0;
        o_push  = 1'b0;
        case (i_mode)
            MODE_OPEN, MODE_CLOSE: begin
                o_push         = i_valid && !i_full;
                o_entry.len    = LEN_W'(1);
                o_entry.bytes[0] = QUOTE_BYTE;
            end
            MODE_CHAR: begin
                o_push = i_valid && !i_full;
                if (i_code_point[CP_W-1:7] == '0) begin
                    o_entry.len      = LEN_W'(1);
                    o_entry.bytes[0] = {1'b0, i_code_point[6:0]};
                end else if ((cp32 & MASK_2B) == '0) begin
                    o_entry.len      = LEN_W'(2);
                    o_entry.bytes[0] = LEAD_2B | {3'b000, i_code_point[10:6]};
                    o_entry.bytes[1] = cont[0];
                end else if ((cp32 & MASK_3B) == '0) begin
                    o_entry.len      = LEN_W'(3);
                    o_entry.bytes[0] = LEAD_3B | {4'h0, i_code_point[15:12]};
                    o_entry.bytes[1] = cont[1];
                    o_entry.bytes[2] = cont[0];
                end else if ((cp32 & MASK_4B) == '0) begin
                    o_entry.len      = LEN_W'(4);
                    o_entry.bytes[0] = LEAD_4B | {5'h00, i_code_point[20:18]};
                    o_entry.bytes[1] = cont[2];
                    o_entry.bytes[2] = cont[1];
                    o_entry.bytes[3] = cont[0];
                end else if ((cp32 & MASK_5B) == '0) begin
                    o_entry.len      = LEN_W'(5);
                    o_entry.bytes[0] = LEAD_5B | {6'h00, i_code_point[25:24]};
                    o_entry.bytes[1] = cont[3];
                    o_entry.bytes[2] = cont[2];
                    o_entry.bytes[3] = cont[1];
                    o_entry.bytes[4] = cont[0];
                end else begin
                    o_entry.len      = LEN_W'(6);
                    o_entry.bytes[0] = LEAD_6B | {7'h00, i_code_point[30]};
                    o_entry.bytes[1] = cont[4];
                    o_entry.bytes[2] = cont[3];
                    o_entry.bytes[3] = cont[2];
                    o_entry.bytes[4] = cont[1];
                    o_entry.bytes[5] = cont[0];
                end
            end
            default: begin
                // unused mode: accept and drop
                o_push = 1'b0;
            end
        endcase
    end

endmodule

[rtl/qu8enc_queue.sv]
// ----------------------------------------------------------------------------
// qu8enc_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module qu8enc_queue import qu8enc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`include "quoted_utf8_string_encoder_assert.svh"

    `QU8_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, o_full, !i_push)
    `QU8_ASSERT_SAME(a_no_pop_when_empty, i_clk, i_rst_n, o_empty, !i_pop)

endmodule

[rtl/qu8enc_back.sv]
// ----------------------------------------------------------------------------
// qu8enc_back
// Serializes the head item of the queue into a registered byte stream.
// ----------------------------------------------------------------------------
module qu8enc_back import qu8enc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_entry      i_head,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_item
);

    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             slot_free;
    logic             take;
    logic             is_last;

    assign slot_free = !r_valid || !i_stall;
    assign take      = slot_free && !i_empty;
    assign is_last   = (r_idx == LEN_W'(i_head.len - LEN_W'(1)));
    assign o_pop     = take && is_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
            n_idx   = is_last ? '0 : r_idx + LEN_W'(1);
        end else if (slot_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= is_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_last_of_item = r_last;

`include "quoted_utf8_string_encoder_assert.svh"

    `QU8_ASSERT_NEXT(a_hold_index_on_stall, i_clk, i_rst_n, r_valid && i_stall, $stable(r_idx))
    `QU8_ASSERT_NEXT(a_index_restarts, i_clk, i_rst_n, o_pop, r_idx == '0 && r_last)

endmodule

[tb/sv/quoted_utf8_string_encoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_utf8_string_encoder_tb
// Drives quote marks, code points of every UTF-8 length class, and unused
// modes through the encoder with random idle cycles on both channels. A local
// encoder predicts the byte stream, and every output byte and its end-of-item
// flag are checked in order.
// ----------------------------------------------------------------------------
module quoted_utf8_string_encoder_tb import qu8enc_pkg::*;;

    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [30:0] CP_ALL_ONES = 31'h7fffffff;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_utf8_byte;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [1:0]      i_mode;
    logic [CP_W-1:0] i_code_point;
    logic            o_valid;
    logic            i_stall;
    logic [7:0]      o_out_byte;
    logic            o_last_of_item;

    t_utf8_byte pending_bytes[$];
    int         error_count;
    bit         send_gaps_on;
    bit         recv_stall_on;
    int         stall_cnt;

    quoted_utf8_string_encoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_code_point   (i_code_point),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Expected byte sequence for one accepted item, appended in stream order.
    function automatic void predict_utf8(input logic [1:0] mode, input logic [30:0] cp);
        logic [31:0] v;
        logic [7:0]  seq [MAX_BYTES];
        logic [7:0]  lead;
        int          n;
        t_utf8_byte  b;
        v = {1'b0, cp};
        if (mode == MODE_OPEN || mode == MODE_CLOSE) begin
            b.data = QUOTE_BYTE;
            b.last = 1'b1;
            pending_bytes.push_back(b);
        end else if (mode == MODE_CHAR) begin
            if (v < 32'h80) begin
                b.data = v[7:0];
                b.last = 1'b1;
                pending_bytes.push_back(b);
            end else begin
                if ((v & MASK_2B) == 0)
                    n = 2;
                else if ((v & MASK_3B) == 0)
                    n = 3;
                else if ((v & MASK_4B) == 0)
                    n = 4;
                else if ((v & MASK_5B) == 0)
                    n = 5;
                else
                    n = 6;
                for (int i = n - 1; i > 0; i--) begin
                    seq[i] = CONT_TAG | {2'b00, v[5:0]};
                    v = v >> 6;
                end
                case (n)
                    2: lead = LEAD_2B;
                    3: lead = LEAD_3B;
                    4: lead = LEAD_4B;
                    5: lead = LEAD_5B;
                    default: lead = LEAD_6B;
                endcase
                seq[0] = lead | v[7:0];
                for (int i = 0; i < n; i++) begin
                    b.data = seq[i];
                    b.last = (i == n - 1);
                    pending_bytes.push_back(b);
                end
            end
        end
        // unused mode: accepted, no bytes
    endfunction

    function automatic logic [30:0] rand_code_point();
        int cls;
        cls = $urandom_range(0, 9);
        case (cls)
            0, 1, 2, 3: return 31'($urandom_range(0, 32'h7f));
            4: return 31'($urandom_range(32'h80, 32'h7ff));
            5: return 31'($urandom_range(32'h800, 32'hffff));
            6: return 31'($urandom_range(32'h10000, 32'h1fffff));
            7: return 31'($urandom_range(32'h200000, 32'h3ffffff));
            8: return 31'($urandom_range(32'h4000000, 32'h7fffffff));
            default: return 31'($urandom() & {1'b0, CP_ALL_ONES});
        endcase
    endfunction

    function automatic logic [30:0] rand_any_cp();
        return 31'($urandom() & {1'b0, CP_ALL_ONES});
    endfunction

    // Present one transaction and hold it until accepted. Valid stays high on
    // return so a following call can stream without a bubble.
    task automatic send_item(input logic [1:0] mode, input logic [30:0] cp);
        int gap;
        @(negedge i_clk);
        gap = send_gaps_on ? gap_len() : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode       = mode;
        i_code_point = cp;
        i_valid      = 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_utf8(mode, cp);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver side: random stall runs.
    always @(negedge i_clk) begin
        if (!recv_stall_on) begin
            i_stall   = 1'b0;
            stall_cnt = 0;
        end else if (stall_cnt != 0) begin
            stall_cnt--;
        end else if (i_stall) begin
            i_stall   = 1'b0;
            stall_cnt = $urandom_range(0, 6);
        end else begin
            stall_cnt = gap_len();
            if (stall_cnt != 0) begin
                i_stall = 1'b1;
                stall_cnt--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_utf8_byte exp_b;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0b", $time, o_out_byte,
                         o_last_of_item);
                error_count++;
            end else begin
                exp_b = pending_bytes.pop_front();
                if (o_out_byte !== exp_b.data) begin
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             exp_b.data, o_out_byte);
                    error_count++;
                end
                if (o_last_of_item !== exp_b.last) begin
                    $display("%0t: last_of_item expected %0b actual %0b", $time,
                             exp_b.last, o_last_of_item);
                    error_count++;
                end
            end
        end
    end

    // Length boundaries, quotes, zero, all-ones and the unused mode.
    task automatic test_directed();
        send_item(MODE_OPEN, 31'h0);
        send_item(MODE_CHAR, 31'h0);
        send_item(MODE_CHAR, 31'h7f);
        send_item(MODE_CHAR, 31'h80);
        send_item(MODE_CHAR, 31'h7ff);
        send_item(MODE_CHAR, 31'h800);
        send_item(MODE_CHAR, 31'hffff);
        send_item(MODE_CHAR, 31'h10000);
        send_item(MODE_CHAR, 31'h1fffff);
        send_item(MODE_CHAR, 31'h200000);
        send_item(MODE_CHAR, 31'h3ffffff);
        send_item(MODE_CHAR, 31'h4000000);
        send_item(MODE_CHAR, CP_ALL_ONES);
        send_item(MODE_CHAR, 31'h22);
        send_item(MODE_CLOSE, 31'h0);
        // code point must be ignored on quotes
        send_item(MODE_OPEN, CP_ALL_ONES);
        send_item(MODE_CLOSE, CP_ALL_ONES);
        send_item(MODE_UNUSED, CP_ALL_ONES);
        send_item(MODE_UNUSED, 31'h0);
        send_item(MODE_CHAR, 31'h2aaaaaaa);
        send_item(MODE_CHAR, 31'h55555555);
    endtask

    // No idling anywhere: fill the item queue and stream one byte per cycle.
    task automatic test_back_to_back();
        send_gaps_on  = 1'b0;
        recv_stall_on = 1'b0;
        send_item(MODE_OPEN, 31'h0);
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_item(MODE_CHAR, rand_code_point());
            else
                send_item(MODE_CHAR, 31'($urandom_range(0, 32'h7f)));
        end
        send_item(MODE_CLOSE, 31'h0);
        send_gaps_on  = 1'b1;
        recv_stall_on = 1'b1;
    endtask

    // Hold off the sender until the output has fully drained, then resume.
    task automatic test_drain_pause();
        send_item(MODE_OPEN, 31'h0);
        send_item(MODE_CHAR, CP_ALL_ONES);
        send_item(MODE_CHAR, 31'h800);
        wait_drained();
        send_item(MODE_CHAR, 31'h41);
        send_item(MODE_CLOSE, 31'h0);
    endtask

    // Mostly well-formed strings with random content, plus stray items.
    task automatic test_random_strings(input int n_items);
        int sent;
        int n_chars;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
                send_item(MODE_OPEN, rand_any_cp());
                n_chars = $urandom_range(0, 12);
                for (int i = 0; i < n_chars; i++)
                    send_item(MODE_CHAR, rand_code_point());
                send_item(MODE_CLOSE, rand_any_cp());
                sent += n_chars + 2;
            end else if (r == 8) begin
                send_item(MODE_UNUSED, rand_any_cp());
                send_item(MODE_CHAR, rand_code_point());
                sent += 2;
            end else begin
                // unbalanced quotes
                send_item(MODE_CLOSE, rand_any_cp());
                send_item(MODE_CHAR, rand_code_point());
                send_item(MODE_OPEN, rand_any_cp());
                sent += 3;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = MODE_CHAR;
        i_code_point  = '0;
        i_stall       = 1'b0;
        stall_cnt     = 0;
        error_count   = 0;
        send_gaps_on  = 1'b1;
        recv_stall_on = 1'b1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_drain_pause();
        test_random_strings(350);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_bytes.size() == 0) begin
            $display("PASS quoted_utf8_string_encoder");
        end else begin
            $display("FAIL quoted_utf8_string_encoder");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL quoted_utf8_string_encoder");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/qu8enc_pkg.sv
rtl/qu8enc_front.sv
rtl/qu8enc_queue.sv
rtl/qu8enc_back.sv
rtl/quoted_utf8_string_encoder.sv
tb/sv/quoted_utf8_string_encoder_tb.sv
